// ===== src/wbm_pkg.sv =====
package wbm_pkg;

    localparam logic [1:0] CMD_X      = 2'd0;
    localparam logic [1:0] CMD_Y      = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [1:0] OP_AND = 2'd0;
    localparam logic [1:0] OP_OR  = 2'd1;
    localparam logic [1:0] OP_XOR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_WAIT  = 2'd1;
    localparam logic [1:0] ST_ZERO_FILL = 2'd2;

    localparam logic [31:0] FILL_FLAG = 32'h8000_0000;
    localparam logic [31:0] ONE_FILL  = 32'hC000_0000;
    localparam logic [31:0] ZERO_PAIR = 32'h8000_0002;
    localparam logic [31:0] ONE_PAIR  = 32'hC000_0002;
    localparam logic [30:0] LIT_MASK  = 31'h7FFF_FFFF;
    localparam logic [29:0] CNT_MASK  = 30'h3FFF_FFFF;

    localparam int unsigned QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] word;
        logic [30:0] x_tail;
        logic [30:0] y_tail;
        logic [4:0]  tail_count;
    } t_item;

    typedef struct packed {
        logic        word_valid;
        logic [31:0] out_word;
        logic        is_tail;
        logic [4:0]  out_tail_count;
        logic        need_x;
        logic        need_y;
        logic        last;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        t_result first;
        t_result second;
        logic    push_two;
    } t_core_out;

    function automatic logic [30:0] apply_op(input logic [1:0] op, input logic [30:0] a,
                                             input logic [30:0] b);
        logic [30:0] r;
        case (op)
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage

// ===== src/wbm_core.sv =====
module wbm_core
    import wbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_item     i_item,
    input  logic [1:0] i_logic_op,
    output t_core_out o_core
);

    logic        r_x_is_fill, r_x_fv, r_y_is_fill, r_y_fv, r_held_valid;
    logic [29:0] r_x_rem, r_y_rem;
    logic [30:0] r_x_lit, r_y_lit;
    logic [31:0] r_held_word;

    logic        n_x_is_fill, n_x_fv, n_y_is_fill, n_y_fv, n_held_valid;
    logic [29:0] n_x_rem, n_y_rem;
    logic [30:0] n_x_lit, n_y_lit;
    logic [31:0] n_held_word;

    always_comb begin
        logic [1:0]  st;
        logic        emit;
        logic [31:0] emit_w;
        logic [29:0] side_rem;
        logic        both_fill;
        logic [29:0] run;
        logic [29:0] consume;
        logic [30:0] fill_v;
        logic        fbit;
        logic [30:0] a;
        logic [30:0] b;
        logic [30:0] v;
        logic [31:0] base;
        logic        same;
        logic [30:0] sum;
        t_result     tail_res;

        n_x_is_fill  = r_x_is_fill;
        n_x_fv       = r_x_fv;
        n_x_rem      = r_x_rem;
        n_x_lit      = r_x_lit;
        n_y_is_fill  = r_y_is_fill;
        n_y_fv       = r_y_fv;
        n_y_rem      = r_y_rem;
        n_y_lit      = r_y_lit;
        n_held_word  = r_held_word;
        n_held_valid = r_held_valid;
        st           = ST_OK;
        emit         = 1'b0;
        emit_w       = 32'd0;
        side_rem     = (i_item.cmd == CMD_X) ? r_x_rem : r_y_rem;
        both_fill    = 1'b0;
        run          = 30'd0;
        consume      = 30'd0;
        fill_v       = 31'd0;
        fbit         = 1'b0;
        a            = 31'd0;
        b            = 31'd0;
        v            = 31'd0;
        base         = 32'd0;
        same         = 1'b0;
        sum          = 31'd0;
        o_core       = '0;

        tail_res = '{word_valid: 1'b0,
                     out_word: {1'b0, apply_op(i_logic_op, i_item.x_tail, i_item.y_tail)},
                     is_tail: 1'b1, out_tail_count: i_item.tail_count,
                     need_x: 1'b1, need_y: 1'b1, last: 1'b1, status: ST_OK};

        case (i_item.cmd)
            CMD_FINISH: begin
                n_x_is_fill  = 1'b0;
                n_x_fv       = 1'b0;
                n_x_rem      = 30'd0;
                n_x_lit      = 31'd0;
                n_y_is_fill  = 1'b0;
                n_y_fv       = 1'b0;
                n_y_rem      = 30'd0;
                n_y_lit      = 31'd0;
                n_held_word  = 32'd0;
                n_held_valid = 1'b0;
                if (r_held_valid) begin
                    o_core.first = '{word_valid: 1'b1, out_word: r_held_word, is_tail: 1'b0,
                                     out_tail_count: 5'd0, need_x: 1'b1, need_y: 1'b1,
                                     last: 1'b0, status: ST_OK};
                    o_core.second   = tail_res;
                    o_core.push_two = 1'b1;
                end else begin
                    o_core.first = tail_res;
                end
            end
            CMD_X, CMD_Y: begin
                if (side_rem != 30'd0) begin
                    st = ST_NOT_WAIT;
                end else if (i_item.word[31]) begin
                    if (i_item.word[29:0] == 30'd0) begin
                        st = ST_ZERO_FILL;
                    end else if (i_item.cmd == CMD_X) begin
                        n_x_is_fill = 1'b1;
                        n_x_fv      = i_item.word[30];
                        n_x_rem     = i_item.word[29:0];
                    end else begin
                        n_y_is_fill = 1'b1;
                        n_y_fv      = i_item.word[30];
                        n_y_rem     = i_item.word[29:0];
                    end
                end else if (i_item.cmd == CMD_X) begin
                    n_x_is_fill = 1'b0;
                    n_x_lit     = i_item.word[30:0];
                    n_x_rem     = 30'd1;
                end else begin
                    n_y_is_fill = 1'b0;
                    n_y_lit     = i_item.word[30:0];
                    n_y_rem     = 30'd1;
                end

                if (st == ST_OK && n_x_rem != 30'd0 && n_y_rem != 30'd0) begin
                    both_fill = n_x_is_fill & n_y_is_fill;
                    run       = (n_x_rem < n_y_rem) ? n_x_rem : n_y_rem;
                    fill_v    = apply_op(i_logic_op, {31{n_x_fv}}, {31{n_y_fv}});
                    fbit      = fill_v[0];
                    a         = n_x_is_fill ? {31{n_x_fv}} : n_x_lit;
                    b         = n_y_is_fill ? {31{n_y_fv}} : n_y_lit;
                    consume   = both_fill ? run : 30'd1;
                    n_x_rem   = n_x_rem - consume;
                    n_y_rem   = n_y_rem - consume;

                    if (both_fill && (run > 30'd1 || !r_held_valid)) begin
                        base = fbit ? ONE_FILL : FILL_FLAG;
                        same = fbit ? (r_held_word[31:30] == 2'b11)
                                    : (r_held_word[31:30] == 2'b10);
                        sum  = {1'b0, r_held_word[29:0]} + {1'b0, run};
                        if (!r_held_valid) begin
                            n_held_word  = base | {2'b00, run};
                            n_held_valid = 1'b1;
                        end else if (same && sum <= {1'b0, CNT_MASK}) begin
                            n_held_word = {r_held_word[31:30], sum[29:0]};
                        end else begin
                            emit        = 1'b1;
                            emit_w      = r_held_word;
                            n_held_word = base | {2'b00, run};
                        end
                    end else begin
                        v = both_fill ? {31{fbit}} : apply_op(i_logic_op, a, b);
                        if (!r_held_valid) begin
                            n_held_word  = {1'b0, v};
                            n_held_valid = 1'b1;
                        end else if (v == 31'd0 && r_held_word == 32'd0) begin
                            n_held_word = ZERO_PAIR;
                        end else if (v == 31'd0 && r_held_word[31:30] == 2'b10
                                     && r_held_word[29:0] != CNT_MASK) begin
                            n_held_word = {r_held_word[31:30], r_held_word[29:0] + 30'd1};
                        end else if (v == LIT_MASK && r_held_word == {1'b0, LIT_MASK}) begin
                            n_held_word = ONE_PAIR;
                        end else if (v == LIT_MASK && r_held_word[31:30] == 2'b11
                                     && r_held_word[29:0] != CNT_MASK) begin
                            n_held_word = {r_held_word[31:30], r_held_word[29:0] + 30'd1};
                        end else begin
                            emit        = 1'b1;
                            emit_w      = r_held_word;
                            n_held_word = {1'b0, v};
                        end
                    end
                end
                o_core.first = '{word_valid: emit, out_word: emit_w, is_tail: 1'b0,
                                 out_tail_count: 5'd0, need_x: (n_x_rem == 30'd0),
                                 need_y: (n_y_rem == 30'd0), last: 1'b1, status: st};
            end
            default: begin
                o_core.first = '{word_valid: 1'b0, out_word: 32'd0, is_tail: 1'b0,
                                 out_tail_count: 5'd0, need_x: (r_x_rem == 30'd0),
                                 need_y: (r_y_rem == 30'd0), last: 1'b1,
                                 status: ST_NOT_WAIT};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_is_fill  <= 1'b0;
            r_x_fv       <= 1'b0;
            r_x_rem      <= 30'd0;
            r_x_lit      <= 31'd0;
            r_y_is_fill  <= 1'b0;
            r_y_fv       <= 1'b0;
            r_y_rem      <= 30'd0;
            r_y_lit      <= 31'd0;
            r_held_word  <= 32'd0;
            r_held_valid <= 1'b0;
        end else if (i_accept) begin
            r_x_is_fill  <= n_x_is_fill;
            r_x_fv       <= n_x_fv;
            r_x_rem      <= n_x_rem;
            r_x_lit      <= n_x_lit;
            r_y_is_fill  <= n_y_is_fill;
            r_y_fv       <= n_y_fv;
            r_y_rem      <= n_y_rem;
            r_y_lit      <= n_y_lit;
            r_held_word  <= n_held_word;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

// ===== src/wbm_outq.sv =====
module wbm_outq
    import wbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_core_out i_core,
    input  logic      i_stall,
    output logic      o_valid,
    output t_result   o_result,
    output logic      o_full
);

    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

    t_result       r_q [QUEUE_DEPTH];
    t_result       n_q [QUEUE_DEPTH];
    logic [CntW-1:0] r_cnt, n_cnt;

    always_comb begin
        logic            pop;
        logic [CntW-1:0] base;
        logic [CntW-1:0] base2;

        pop   = (r_cnt != '0) && !i_stall;
        base  = r_cnt - {{(CntW-1){1'b0}}, pop};
        base2 = base + {{(CntW-1){1'b0}}, 1'b1};
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) begin
                n_q[i] = r_q[i+1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push && base == CntW'(i)) begin
                n_q[i] = i_core.first;
            end
            if (i_push && i_core.push_two && base2 == CntW'(i)) begin
                n_q[i] = i_core.second;
            end
        end
        n_cnt = base;
        if (i_push) begin
            n_cnt = i_core.push_two ? base + CntW'(2) : base2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_valid  = (r_cnt != '0);
    assign o_result = r_q[IdxW'(0)];
    assign o_full   = (r_cnt >= CntW'(QUEUE_DEPTH - 1));

endmodule

// ===== src/wah_bitmap_logic_merge.sv =====
// Streaming AND/OR/XOR merge of two WAH-compressed bitmaps.
// Input channel (i_valid, o_stall, i_item): one compressed word of operand x
// or y, or a finish command that carries the partial tail words. A transfer
// takes place at a clock edge with valid high and stall low.
// Output channel (o_valid, i_stall, o_result): every word item yields one
// result, a finish yields two (flushed held word, then tail) or just the tail.
// The operation is set through the APB register at address 0 while idle.
// Each result enters the result queue at the edge that transfers its item.
// Throughput: one item per cycle while o_stall is low; the decode, combine
// and fold logic sits between the input port and a three-entry result queue.
// A finish with a held word writes both of its results in the same push.
// o_stall rises when the result queue holds two or more entries, so the
// receiver may stall freely and results wait in the queue without loss.
// Reset (synchronous, active low) empties both runs, drops the held word,
// clears the queue and selects AND.
module wah_bitmap_logic_merge
    import wbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] r_op;
    logic       accept;
    logic       full;
    t_core_out  core;

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : {30'd0, r_op};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_AND;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_op <= pwdata[1:0];
        end
    end

    assign o_stall = full;
    assign accept  = i_valid && !o_stall;

    wbm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_logic_op (r_op),
        .o_core     (core)
    );

    wbm_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_core   (core),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_full   (full)
    );

endmodule

// ===== src/wbm_checker.sv =====
module wbm_checker
    import wbm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input t_result     o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result offered right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("Stalled result changed.");

    a_item_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("Transferred item left no result.");

    a_tail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_tail |-> o_result.need_x && o_result.need_y
                                        && o_result.last && !o_result.word_valid)
        else $error("Tail result with wrong flags.");

    a_flush_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> o_result.word_valid && !o_result.is_tail)
        else $error("Non-final result without a flushed word.");

endmodule

bind wah_bitmap_logic_merge wbm_checker u_wbm_checker (.*);
